[rtl/core/tcf_pkg.sv]
// ============================================================================
// tcf_pkg: shared types and constants of the threshold count 3x3 filter
// Item payloads, the stage record between scan control and the window stage,
// register indexes and the sequencer state type.
// ============================================================================
package tcf_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;

    localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COUNT_LIMIT     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT    = 2'd3;

    // Register reset values
    localparam logic [7:0] RST_LEVEL_THRESHOLD = 8'd30;
    localparam logic [3:0] RST_COUNT_LIMIT     = 4'd7;
    localparam logic [9:0] RST_IMAGE_WIDTH     = 10'd320;
    localparam logic [9:0] RST_IMAGE_HEIGHT    = 10'd180;

    // Smallest frame edge in use
    localparam logic [9:0] MIN_SIZE = 10'd3;

    // Item kinds
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    // Output levels
    localparam logic [7:0] PIXEL_SET   = 8'hFF;
    localparam logic [7:0] PIXEL_CLEAR = 8'h00;

    // Output queue geometry
    localparam int OUTQ_DEPTH = 2;
    localparam int OUTQ_CNT_W = 2;
    localparam int OUTQ_PTR_W = 1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] pixel_in;
    } pix_item_t;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic       frame_last;
    } res_item_t;

    // Control record carried from acceptance to the window stage
    typedef struct packed {
        logic valid;
        logic pixel;
        logic mark;
        logic emit;
        logic use_window;
        logic last;
    } stage_t;

    typedef enum logic [1:0] {
        SEQ_CLAMP,
        SEQ_SCALE,
        SEQ_WRAP,
        SEQ_RUN
    } seq_state_t;

endpackage

[rtl/core/tcf_ram.sv]
// ============================================================================
// tcf_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ============================================================================
module tcf_ram #(
    parameter int DATA_W = 2,
    parameter int DEPTH  = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

[rtl/core/tcf_scan.sv]
// ============================================================================
// tcf_scan: scan position, pending count and frame geometry
// Tracks where the next pixel lands, how many outputs are owed, and the frame
// position of the next output. Recomputes geometry after a size write.
// ============================================================================
module tcf_scan #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               fire,
    input  tcf_pkg::pix_item_t                 item,
    input  logic [7:0]                         level_threshold,
    input  logic [9:0]                         cfg_width,
    input  logic [9:0]                         cfg_height,
    input  logic                               size_wr,
    output logic                               busy,
    output logic                               ram_re,
    output logic [$clog2(MAX_WIDTH)-1:0]       ram_raddr,
    output tcf_pkg::stage_t                    stage,
    output logic [$clog2(MAX_WIDTH)-1:0]       stage_addr
);

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int WU_W    = $clog2(MAX_WIDTH + 1);
    localparam int HU_W    = $clog2(MAX_HEIGHT + 1);
    localparam int PEND_W  = $clog2(MAX_WIDTH + 2);
    localparam int FRAME_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int ACC_W   = ((FRAME_W > PEND_W) ? FRAME_W : PEND_W) + 1;

    tcf_pkg::seq_state_t state_reg, state_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [PEND_W-1:0]   pend_reg, pend_next;
    logic [FRAME_W-1:0]  pos_reg, pos_next;
    logic [FRAME_W-1:0]  frame_reg, frame_next;
    logic [WU_W-1:0]     w_use_reg, w_use_next;
    logic [HU_W-1:0]     h_use_reg, h_use_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    tcf_pkg::stage_t     stage_reg, stage_next;
    logic [COL_W-1:0]    addr1_reg;

    logic [WU_W-1:0]    w_last;
    logic [HU_W-1:0]    h_last;
    logic [COL_W-1:0]   col_c;
    logic [ROW_W-1:0]   row_c;
    logic [FRAME_W-1:0] lin;
    logic [PEND_W-1:0]  pend_w;
    logic               col_at_end;
    logic               is_pixel;
    logic               emit;
    logic               last;

    assign w_last   = w_use_reg - WU_W'(1);
    assign h_last   = h_use_reg - HU_W'(1);
    assign col_c    = (WU_W'(col_reg) > w_last) ? COL_W'(w_last) : col_reg;
    assign row_c    = (HU_W'(row_reg) > h_last) ? ROW_W'(h_last) : row_reg;
    assign lin      = FRAME_W'(row_c) * FRAME_W'(w_use_reg) + FRAME_W'(col_c);
    assign pend_w   = PEND_W'(w_use_reg);
    assign col_at_end = (WU_W'(col_reg) == w_last);
    assign is_pixel = (item.req_type == tcf_pkg::REQ_PIXEL);
    assign emit     = is_pixel ? (pend_reg > pend_w) : (pend_reg != '0);
    assign last     = (pos_reg == frame_reg - FRAME_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcf_pkg::SEQ_CLAMP;
            col_reg   <= '0;
            row_reg   <= '0;
            pend_reg  <= '0;
            stage_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            pend_reg  <= pend_next;
            stage_reg <= stage_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        frame_reg <= frame_next;
        w_use_reg <= w_use_next;
        h_use_reg <= h_use_next;
        acc_reg   <= acc_next;
        addr1_reg <= col_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        pend_next  = pend_reg;
        pos_next   = pos_reg;
        frame_next = frame_reg;
        w_use_next = w_use_reg;
        h_use_next = h_use_reg;
        acc_next   = acc_reg;
        stage_next = '0;

        unique case (state_reg)
            tcf_pkg::SEQ_CLAMP:
            begin
                // Clamp the size registers to the supported range
                if (cfg_width < tcf_pkg::MIN_SIZE)
                    w_use_next = WU_W'(tcf_pkg::MIN_SIZE);
                else if (32'(cfg_width) > MAX_WIDTH)
                    w_use_next = WU_W'(MAX_WIDTH);
                else
                    w_use_next = WU_W'(cfg_width);
                if (cfg_height < tcf_pkg::MIN_SIZE)
                    h_use_next = HU_W'(tcf_pkg::MIN_SIZE);
                else if (32'(cfg_height) > MAX_HEIGHT)
                    h_use_next = HU_W'(MAX_HEIGHT);
                else
                    h_use_next = HU_W'(cfg_height);
                state_next = tcf_pkg::SEQ_SCALE;
            end
            tcf_pkg::SEQ_SCALE:
            begin
                // Pull the position inside the frame, start the output position
                col_next   = col_c;
                row_next   = row_c;
                frame_next = FRAME_W'(w_use_reg) * FRAME_W'(h_use_reg);
                acc_next   = $signed(ACC_W'(lin)) - $signed(ACC_W'(pend_reg));
                state_next = tcf_pkg::SEQ_WRAP;
            end
            tcf_pkg::SEQ_WRAP:
            begin
                // Add frames until the output position is non-negative
                if (acc_reg[ACC_W-1])
                begin
                    acc_next = acc_reg + $signed(ACC_W'(frame_reg));
                end
                else
                begin
                    pos_next   = acc_reg[FRAME_W-1:0];
                    state_next = tcf_pkg::SEQ_RUN;
                end
            end
            tcf_pkg::SEQ_RUN:
            begin
                if (fire)
                begin
                    stage_next.valid = 1'b1;
                    stage_next.pixel = is_pixel;
                    stage_next.mark  = (item.pixel_in > level_threshold);
                    stage_next.emit  = emit;
                    stage_next.last  = emit && last;
                    stage_next.use_window = is_pixel &&
                        (pend_reg == pend_w + PEND_W'(1)) &&
                        (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));

                    if (emit)
                    begin
                        pos_next = last ? '0 : pos_reg + FRAME_W'(1);
                    end

                    if (is_pixel)
                    begin
                        if (!emit)
                        begin
                            pend_next = pend_reg + PEND_W'(1);
                        end
                        if (col_at_end)
                        begin
                            col_next = '0;
                            row_next = (HU_W'(row_reg) == h_last) ? '0
                                                                 : row_reg + ROW_W'(1);
                        end
                        else
                        begin
                            col_next = col_reg + COL_W'(1);
                        end
                    end
                    else if (emit)
                    begin
                        pend_next = pend_reg - PEND_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = tcf_pkg::SEQ_CLAMP;
            end
        endcase

        if (size_wr)
        begin
            state_next = tcf_pkg::SEQ_CLAMP;
        end
    end

    assign busy       = (state_reg != tcf_pkg::SEQ_RUN);
    assign ram_re     = fire && is_pixel;
    assign ram_raddr  = col_reg;
    assign stage      = stage_reg;
    assign stage_addr = addr1_reg;

endmodule

[rtl/core/tcf_window.sv]
// ============================================================================
// tcf_window: 3x3 mark window and line store write-back
// Shifts the new mark column into the window, counts the set marks and
// writes the shifted marks back to the line store.
// ============================================================================
module tcf_window #(
    parameter int ADDR_W = 9
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tcf_pkg::stage_t      stage,
    input  logic [ADDR_W-1:0]    stage_addr,
    input  logic [1:0]           rdata,
    input  logic [3:0]           count_limit,
    output logic                 ram_we,
    output logic [ADDR_W-1:0]    ram_waddr,
    output logic [1:0]           ram_wdata,
    output logic                 push,
    output tcf_pkg::res_item_t   push_item
);

    logic [8:0] window_reg, window_next;
    logic [2:0] newcol;
    logic [3:0] set_count;

    // Memory word: bit 1 middle row mark, bit 0 upper row mark
    assign newcol      = {stage.mark, rdata[1], rdata[0]};
    assign window_next = {newcol, window_reg[8:3]};

    always_comb
    begin
        set_count = '0;
        for (int i = 0; i < 9; i++)
        begin
            set_count = set_count + 4'(window_next[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else if (stage.valid && stage.pixel)
        begin
            window_reg <= window_next;
        end
    end

    // Age the marks: middle row moves up, new mark becomes middle row
    assign ram_we    = stage.valid && stage.pixel;
    assign ram_waddr = stage_addr;
    assign ram_wdata = {stage.mark, rdata[1]};

    assign push                 = stage.valid && stage.emit;
    assign push_item.pixel_out  = (stage.use_window && (set_count > count_limit))
                                  ? tcf_pkg::PIXEL_SET : tcf_pkg::PIXEL_CLEAR;
    assign push_item.frame_last = stage.last;

endmodule

[rtl/core/tcf_outq.sv]
// ============================================================================
// tcf_outq: two-entry result queue
// Holds finished results so that the input side keeps moving while the
// output side stalls.
// ============================================================================
module tcf_outq (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  tcf_pkg::res_item_t                  push_item,
    input  logic                                pop,
    output logic                                res_valid,
    output tcf_pkg::res_item_t                  res_item,
    output logic [tcf_pkg::OUTQ_CNT_W-1:0]      count
);

    tcf_pkg::res_item_t                  q_reg [tcf_pkg::OUTQ_DEPTH];
    logic [tcf_pkg::OUTQ_PTR_W-1:0]      wr_ptr_reg;
    logic [tcf_pkg::OUTQ_PTR_W-1:0]      rd_ptr_reg;
    logic [tcf_pkg::OUTQ_CNT_W-1:0]      count_reg, count_next;

    always_comb
    begin
        priority case ({push, pop})
            2'b10:   count_next = count_reg + tcf_pkg::OUTQ_CNT_W'(1);
            2'b01:   count_next = count_reg - tcf_pkg::OUTQ_CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + tcf_pkg::OUTQ_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + tcf_pkg::OUTQ_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign res_valid = (count_reg != '0);
    assign res_item  = q_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

[rtl/core/threshold_count_3x3_filter_unit.sv]
// ============================================================================
// threshold_count_3x3_filter_unit: streaming 3x3 mark-count smoothing filter
// Pixels arrive in raster order and are marked set when above level_threshold.
// Each interior output is 255 when more than count_limit marks of its 3x3
// neighborhood are set, else 0; border outputs are 0. Outputs lag the input by
// one row plus one pixel; drain items flush the owed tail of a frame. The
// block takes one item per clock unless stalled: the mark line store is one
// RAM, read in the cycle an item is accepted and written back in the next,
// and a result enters the output queue from the window stage. A two-entry
// queue lets the input keep flowing while the output stalls. After a write to
// image_width or image_height the geometry is recomputed and input is stalled
// while the sequencer steps through clamp, scale and wrap, the wrap step
// adding frame sizes until the output position is non-negative. The
// sequence also runs once after reset. Configuration writes are always taken.
// ============================================================================
module threshold_count_3x3_filter_unit #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // pixel and drain items
    input  logic                                pix_valid,
    output logic                                pix_stall,
    input  tcf_pkg::pix_item_t                  pix_item,
    // filtered results
    output logic                                res_valid,
    input  logic                                res_stall,
    output tcf_pkg::res_item_t                  res_item,
    // register writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tcf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tcf_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    // Configuration registers
    logic [7:0] level_threshold_reg;
    logic [3:0] count_limit_reg;
    logic [9:0] image_width_reg;
    logic [9:0] image_height_reg;

    logic cfg_fire;
    logic size_wr;
    logic fire;
    logic busy;

    logic                 ram_re;
    logic [COL_W-1:0]     ram_raddr;
    logic                 ram_we;
    logic [COL_W-1:0]     ram_waddr;
    logic [1:0]           ram_wdata;
    logic [1:0]           ram_rdata;

    tcf_pkg::stage_t      stage;
    logic [COL_W-1:0]     stage_addr;

    logic                 q_push;
    tcf_pkg::res_item_t   q_push_item;
    logic                 q_pop;
    logic [tcf_pkg::OUTQ_CNT_W-1:0] q_count;
    logic [2:0]           occupancy;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign size_wr   = cfg_fire && ((cfg_index == tcf_pkg::REG_IMAGE_WIDTH) ||
                                    (cfg_index == tcf_pkg::REG_IMAGE_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_threshold_reg <= tcf_pkg::RST_LEVEL_THRESHOLD;
            count_limit_reg     <= tcf_pkg::RST_COUNT_LIMIT;
            image_width_reg     <= tcf_pkg::RST_IMAGE_WIDTH;
            image_height_reg    <= tcf_pkg::RST_IMAGE_HEIGHT;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                tcf_pkg::REG_LEVEL_THRESHOLD: level_threshold_reg <= cfg_data[7:0];
                tcf_pkg::REG_COUNT_LIMIT:     count_limit_reg     <= cfg_data[3:0];
                tcf_pkg::REG_IMAGE_WIDTH:     image_width_reg     <= cfg_data[9:0];
                tcf_pkg::REG_IMAGE_HEIGHT:    image_height_reg    <= cfg_data[9:0];
            endcase
        end
    end

    // Hold input while geometry is recomputed or when the item in flight plus
    // queued results would leave no room for one more result.
    assign q_pop     = res_valid && !res_stall;
    assign occupancy = 3'(q_count) + 3'(q_push) - 3'(q_pop);
    assign pix_stall = busy || (occupancy >= 3'(tcf_pkg::OUTQ_DEPTH));
    assign fire      = pix_valid && !pix_stall;

    // Advance position, pending count and output position; issue line read
    tcf_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_scan (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (fire),
        .item            (pix_item),
        .level_threshold (level_threshold_reg),
        .cfg_width       (image_width_reg),
        .cfg_height      (image_height_reg),
        .size_wr         (size_wr),
        .busy            (busy),
        .ram_re          (ram_re),
        .ram_raddr       (ram_raddr),
        .stage           (stage),
        .stage_addr      (stage_addr)
    );

    // Marks of the two rows above, one word per column
    tcf_ram #(
        .DATA_W (2),
        .DEPTH  (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shift window, count marks, write back aged marks
    tcf_window #(
        .ADDR_W (COL_W)
    ) u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage       (stage),
        .stage_addr  (stage_addr),
        .rdata       (ram_rdata),
        .count_limit (count_limit_reg),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .push        (q_push),
        .push_item   (q_push_item)
    );

    // Park finished results until the consumer takes them
    tcf_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .pop       (q_pop),
        .res_valid (res_valid),
        .res_item  (res_item),
        .count     (q_count)
    );

`ifndef NO_ASSERTIONS
    // The result queue never takes a result it has no room for
    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && !q_pop && (q_count == 2'(tcf_pkg::OUTQ_DEPTH))))
        else $error("result queue overflow");

    // Write-back goes to the column read in the previous cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ($past(ram_re) && (ram_waddr == $past(ram_raddr))))
        else $error("line store write-back address mismatch");

    // Filtered levels are only ever fully set or fully clear
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((res_item.pixel_out == tcf_pkg::PIXEL_SET) ||
                       (res_item.pixel_out == tcf_pkg::PIXEL_CLEAR)))
        else $error("result level neither set nor clear");
`endif

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb: self-checking bench for threshold_count_3x3_filter_unit
// Streams raster frames and drain items into the filter and predicts every
// filtered pixel with an independent mark/window model kept in step with each
// accepted item. Covers minimum and maximum frame edges, clamped sizes, height
// and width shrinks mid frame, drains mid frame and back-to-back frames.
// Random gaps on the input side and random stalls on the result side.
// ============================================================================
module tb;
    import tcf_pkg::*;

    localparam int MAX_W          = 512;
    localparam int MAX_H          = 512;
    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 11;
    localparam int RANDOM_ITEMS   = 1900;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 20;
    localparam int END_WAIT_LIMIT = 2000;
    localparam int TIMEOUT_NS     = 5_000_000;
    localparam int PRINT_LIMIT    = 50;

    // ------------------------------------------------------------------------
    // Filter prediction: thresholded marks, two line stores, 3x3 window and
    // the owed-output count, advanced once per accepted item.
    // ------------------------------------------------------------------------
    class smoothing_scoreboard;
        logic [7:0] level_threshold;
        logic [3:0] count_limit;
        logic [9:0] image_width;
        logic [9:0] image_height;
        bit         upper_marks [MAX_W];
        bit         middle_marks[MAX_W];
        logic [8:0] window;
        int unsigned col;
        int unsigned row;
        logic [9:0] pending;
        res_item_t  owed[$];
        int         errors;

        function new();
            level_threshold = RST_LEVEL_THRESHOLD;
            count_limit     = RST_COUNT_LIMIT;
            image_width     = RST_IMAGE_WIDTH;
            image_height    = RST_IMAGE_HEIGHT;
            window          = '0;
            col             = 0;
            row             = 0;
            pending         = '0;
            errors          = 0;
        endfunction

        function int unsigned fit_edge(logic [9:0] v, int unsigned hi);
            if (v < MIN_SIZE)
                return MIN_SIZE;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] value);
            case (index)
                REG_LEVEL_THRESHOLD: level_threshold = value[7:0];
                REG_COUNT_LIMIT:     count_limit     = value[3:0];
                REG_IMAGE_WIDTH:     image_width     = value;
                REG_IMAGE_HEIGHT:    image_height    = value;
                default: ;
            endcase
        endfunction

        function void note_item(pix_item_t item);
            int unsigned w;
            int unsigned h;
            int unsigned frame;
            int unsigned c;
            int unsigned r;
            int unsigned pos;
            logic        mark;
            res_item_t   res;
            w     = fit_edge(image_width, MAX_W);
            h     = fit_edge(image_height, MAX_H);
            frame = w * h;
            c     = (col < w) ? col : w - 1;
            r     = (row < h) ? row : h - 1;
            // position of the oldest owed pixel, wrapped within the frame
            pos   = (r * w + c + frame - (pending % frame)) % frame;
            res.frame_last = (pos == frame - 1);
            res.pixel_out  = PIXEL_CLEAR;

            if (item.req_type == REQ_DRAIN) begin
                if (pending != 0) begin
                    owed.push_back(res);
                    pending = pending - 1;
                end
                return;
            end

            mark = (item.pixel_in > level_threshold);
            window = {mark, middle_marks[c], upper_marks[c], window[8:3]};
            upper_marks[c]  = middle_marks[c];
            middle_marks[c] = mark;

            if (pending >= w + 1) begin
                if (pending == w + 1 && r >= 2 && c >= 2 && $countones(window) > count_limit)
                    res.pixel_out = PIXEL_SET;
                owed.push_back(res);
            end
            else begin
                pending = pending + 1;
            end

            if (c + 1 >= w) begin
                col = 0;
                row = (r + 1 >= h) ? 0 : r + 1;
            end
            else begin
                col = c + 1;
                row = r;
            end
        endfunction

        task note_mismatch(string msg);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("%0t ns: mismatch: %s", $time, msg);
        endtask

        task check_result(res_item_t got);
            res_item_t want;
            if (owed.size() == 0) begin
                note_mismatch($sformatf("result %0h/%0b with nothing owed",
                                        got.pixel_out, got.frame_last));
                return;
            end
            want = owed.pop_front();
            if (got.pixel_out !== want.pixel_out)
                note_mismatch($sformatf("pixel_out %0h, predicted %0h",
                                        got.pixel_out, want.pixel_out));
            if (got.frame_last !== want.frame_last)
                note_mismatch($sformatf("frame_last %0b, predicted %0b",
                                        got.frame_last, want.frame_last));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals; every block input starts at a known value
    // ------------------------------------------------------------------------
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   pix_valid = 1'b0;
    logic                   pix_stall;
    pix_item_t              pix_item  = '0;
    logic                   res_valid;
    logic                   res_stall = 1'b0;
    res_item_t              res_item;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_LEVEL_THRESHOLD;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    smoothing_scoreboard sb;
    bit                  idle_on    = 1'b0;
    int                  stall_left = 0;
    int unsigned         items_sent = 0;

    threshold_count_3x3_filter_unit #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_item  (pix_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // Hold the result side off in short random bursts while idling is on.
    always @(negedge clk)
    begin
        if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 3);
        if (stall_left > 0) begin
            res_stall <= 1'b1;
            stall_left--;
        end
        else begin
            res_stall <= 1'b0;
        end
    end

    // Check each result taken at a rising edge against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            sb.check_result(res_item);
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Present one item, optionally after a short gap, and hold it until taken.
    // Valid stays high on return so that the next item follows without a gap.
    task automatic send_item(input logic req, input logic [7:0] level);
        pix_item_t item;
        int        gap;
        item.req_type = req;
        item.pixel_in = level;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            pix_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_valid <= 1'b1;
        pix_item  <= item;
        do @(posedge clk); while (pix_stall);
        sb.note_item(item);
        items_sent++;
    endtask

    // Drop valid, wait for every predicted result, then let the pipe empty.
    task automatic wait_idle();
        @(negedge clk);
        pix_valid <= 1'b0;
        while (sb.owed.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write one register; the block must be idle.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        sb.write_register(index, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Level that is set with a chance of density percent, with some noise.
    function automatic logic [7:0] pick_level(int unsigned density);
        int unsigned thr;
        thr = sb.level_threshold;
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 255);
        if ($urandom_range(1, 100) <= density && thr < 255)
            return $urandom_range(255, thr + 1);
        return $urandom_range(thr, 0);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_threshold();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // Mostly small edges, sometimes below the minimum so the clamp kicks in.
    function automatic logic [CFG_DATA_W-1:0] pick_edge(int unsigned hi);
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 2);
        return $urandom_range(3, hi);
    endfunction

    // Flush every owed pixel of the frame tail with drains.
    task automatic flush_tail();
        while (sb.pending != 0)
            send_item(REQ_DRAIN, $urandom_range(0, 255));
    endtask

    // Advance to the next frame start, then flush the tail.
    task automatic close_frame(input int unsigned density);
        while (sb.col != 0 || sb.row != 0)
            send_item(REQ_PIXEL, pick_level(density));
        flush_tail();
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned density;
        int unsigned stop_at;
        int unsigned n;
        int unsigned k;
        int unsigned spin;
        logic [7:0]  diag_frame [9];

        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // A drain with nothing owed must produce no result.
        send_item(REQ_DRAIN, 8'hA5);

        // Smallest frame, every level counts as set except zero, any set mark
        // in the neighborhood sets the output. Diagonal of marks through the
        // center; the one interior pixel must come out set.
        wait_idle();
        write_reg(REG_LEVEL_THRESHOLD, 10'd0);
        write_reg(REG_COUNT_LIMIT, 10'd0);
        write_reg(REG_IMAGE_WIDTH, 10'd3);
        write_reg(REG_IMAGE_HEIGHT, 10'd3);
        diag_frame = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h80};
        foreach (diag_frame[i])
            send_item(REQ_PIXEL, diag_frame[i]);
        flush_tail();
        send_item(REQ_DRAIN, 8'h00);

        // Sizes below the minimum clamp back to 3x3. A full neighborhood of
        // nine marks must beat a limit of eight, even with a drain mid frame.
        wait_idle();
        write_reg(REG_LEVEL_THRESHOLD, 10'd254);
        write_reg(REG_COUNT_LIMIT, 10'd8);
        write_reg(REG_IMAGE_WIDTH, 10'd1);
        write_reg(REG_IMAGE_HEIGHT, 10'd2);
        for (k = 0; k < 9; k++) begin
            send_item(REQ_PIXEL, 8'hFF);
            if (k == 4)
                send_item(REQ_DRAIN, 8'h00);
        end
        flush_tail();

        // Random phases: retune between phases, then stream raster pixels
        // with a few drains as noise. Widen only at a frame start, so the
        // line stores are always filled before an interior pixel uses them;
        // narrow mid frame only once two full lines are in.
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            idle_on = ($urandom_range(0, 4) != 0);
            density = $urandom_range(0, 100);
            wait_idle();
            if ($urandom_range(0, 1))
                write_reg(REG_LEVEL_THRESHOLD, pick_threshold());
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_COUNT_LIMIT, $urandom_range(0, 9));
            if (sb.col == 0 && sb.row == 0) begin
                if ($urandom_range(0, 1))
                    write_reg(REG_IMAGE_WIDTH, pick_edge(10));
                if ($urandom_range(0, 1))
                    write_reg(REG_IMAGE_HEIGHT, pick_edge(6));
            end
            else begin
                if (sb.row >= 2 && $urandom_range(0, 3) == 0)
                    write_reg(REG_IMAGE_WIDTH,
                              $urandom_range(0, sb.fit_edge(sb.image_width, MAX_W)));
                if ($urandom_range(0, 3) == 0)
                    write_reg(REG_IMAGE_HEIGHT, pick_edge(6));
            end
            n = $urandom_range(4, 40);
            for (k = 0; k < n; k++) begin
                if ($urandom_range(0, 24) == 0)
                    repeat ($urandom_range(1, 3)) send_item(REQ_DRAIN, $urandom_range(0, 255));
                else
                    send_item(REQ_PIXEL, pick_level(density));
            end
            if ($urandom_range(0, 3) == 0) begin
                close_frame(density);
                if ($urandom_range(0, 1))
                    send_item(REQ_DRAIN, $urandom_range(0, 255));
            end
        end

        // Widest line: an out-of-range width clamps to the line store depth.
        idle_on = 1'b1;
        density = $urandom_range(20, 80);
        close_frame(density);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 10'd1023);
        write_reg(REG_IMAGE_HEIGHT, 10'd3);
        write_reg(REG_COUNT_LIMIT, 10'd4);
        write_reg(REG_LEVEL_THRESHOLD, 10'd127);
        repeat (MAX_W * 3) send_item(REQ_PIXEL, pick_level(density));
        flush_tail();

        // Tallest frame clamps to the height limit; shrink it mid frame so
        // the row position clamps to the last row and the frame closes.
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 10'd3);
        write_reg(REG_IMAGE_HEIGHT, 10'd600);
        repeat (90) send_item(REQ_PIXEL, pick_level(density));
        wait_idle();
        write_reg(REG_IMAGE_HEIGHT, 10'd2);
        close_frame(density);

        // Last stretch: no gaps, no stalls, frames back to back.
        idle_on = 1'b0;
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 10'd5);
        write_reg(REG_IMAGE_HEIGHT, 10'd4);
        write_reg(REG_LEVEL_THRESHOLD, 10'd100);
        write_reg(REG_COUNT_LIMIT, 10'd4);
        repeat (60) send_item(REQ_PIXEL, pick_level(50));
        close_frame(50);

        // Drop valid, collect the remaining results, then let the pipe empty.
        @(negedge clk);
        pix_valid <= 1'b0;
        for (spin = 0; spin < END_WAIT_LIMIT && sb.owed.size() != 0; spin++)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.owed.size() != 0)
            sb.note_mismatch($sformatf("%0d predicted results never arrived", sb.owed.size()));

        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
